### hdl/rrts_pkg.sv
`timescale 1ns / 1ps

package rrts_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam logic [7:0] QUANTUM_RESET = 8'd2;
   localparam logic [7:0] SLICE_MAX = 8'd255;

   // One task record as it sits in the ready queue or on the core.
   typedef struct packed {
      logic [7:0]  id;
      logic [11:0] burst;
      logic [11:0] remaining;
      logic [15:0] arrival;
      logic [15:0] first_run;
   } task_type;

   localparam int TASK_W = $bits(task_type);

   // Queue requests for one tick. push1 is only ever set together with push0.
   typedef struct packed {
      logic push0;
      logic push1;
      logic pop;
   } queue_ctrl_type;

endpackage

### hdl/rrts_ram.sv
`timescale 1ns / 1ps

module rrts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/rrts_queue.sv
`timescale 1ns / 1ps

// Ready queue. Storage is split into two banks by the lowest slot bit, so the
// two pushes of one tick (arrival and requeue) land in different banks. The
// physical ring is rounded up to a power of two; the count limits the capacity.
// The head record is prefetched every cycle so it is ready at the next tick.
module rrts_queue
   import rrts_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  queue_ctrl_type               ctrl,
   input  task_type                     rec0,
   input  task_type                     rec1,
   output task_type                     head_rec,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PtrW      = $clog2(DEPTH);
   localparam int CntW      = $clog2(DEPTH + 1);
   localparam int BankDepth = 2 ** (PtrW - 1);
   localparam int BankAw    = (BankDepth > 1) ? $clog2(BankDepth) : 1;

   logic [PtrW-1:0] head_ff, head_in;
   logic [PtrW-1:0] tail_ff, tail_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            sel_ff, sel_in;
   logic            byp_valid_ff, byp_valid_in;
   task_type        byp_rec_ff, byp_rec_in;

   logic [PtrW-1:0] slot0, slot1;
   logic            we0, we1;
   logic [BankAw-1:0] waddr0, waddr1, raddr;
   task_type        wdata0, wdata1, rdata0, rdata1;

   always_comb begin
      slot0    = tail_ff;
      slot1    = tail_ff + PtrW'(1);
      head_in  = head_ff + PtrW'(ctrl.pop);
      tail_in  = tail_ff + PtrW'(ctrl.push0) + PtrW'(ctrl.push1);
      count_in = count_ff + CntW'(ctrl.push0) + CntW'(ctrl.push1) - CntW'(ctrl.pop);
      sel_in   = head_in[0];
      raddr    = BankAw'(head_in >> 1);

      // Bank 0 holds even slots, bank 1 odd slots.
      we0    = (ctrl.push0 && !slot0[0]) || (ctrl.push1 && !slot1[0]);
      we1    = (ctrl.push0 && slot0[0]) || (ctrl.push1 && slot1[0]);
      wdata0 = (ctrl.push0 && !slot0[0]) ? rec0 : rec1;
      wdata1 = (ctrl.push0 && slot0[0]) ? rec0 : rec1;
      waddr0 = (ctrl.push0 && !slot0[0]) ? BankAw'(slot0 >> 1) : BankAw'(slot1 >> 1);
      waddr1 = (ctrl.push0 && slot0[0]) ? BankAw'(slot0 >> 1) : BankAw'(slot1 >> 1);

      // A write to the slot being prefetched would be missed by the RAM read.
      byp_valid_in = 1'b0;
      byp_rec_in   = rec0;
      if (ctrl.push0 && slot0 == head_in) begin
         byp_valid_in = 1'b1;
         byp_rec_in   = rec0;
      end else if (ctrl.push1 && slot1 == head_in) begin
         byp_valid_in = 1'b1;
         byp_rec_in   = rec1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         byp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         byp_valid_ff <= byp_valid_in;
      end
      sel_ff     <= sel_in;
      byp_rec_ff <= byp_rec_in;
   end

   rrts_ram #(
      .WIDTH (TASK_W),
      .DEPTH (BankDepth)
   ) u_bank0 (
      .clock (clock),
      .we    (we0),
      .waddr (waddr0),
      .wdata (wdata0),
      .raddr (raddr),
      .rdata (rdata0)
   );

   rrts_ram #(
      .WIDTH (TASK_W),
      .DEPTH (BankDepth)
   ) u_bank1 (
      .clock (clock),
      .we    (we1),
      .waddr (waddr1),
      .wdata (wdata1),
      .raddr (raddr),
      .rdata (rdata1)
   );

   assign head_rec = byp_valid_ff ? byp_rec_ff : (sel_ff ? rdata1 : rdata0);
   assign count    = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("ready queue count exceeds its depth");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      tail_ff == head_ff + PtrW'(count_ff))
      else $error("ready queue pointers disagree with count");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> (count_ff != '0) || ctrl.push0)
      else $error("ready queue popped while empty");

endmodule

### hdl/round_robin_task_scheduler_core.sv
`timescale 1ns / 1ps

// Round-robin scheduler core. Each start pulse is one scheduling tick and is
// taken on every clock (busy stays low), so one tick per cycle is sustained; the
// tick's result appears on the rsp_ ports in the following cycle, marked by a
// one-cycle rsp_valid strobe, and must be captured then because the receiver
// cannot stall the core. The whole tick (queue push, pop, slice check, finish
// and timing arithmetic) is resolved combinationally against a queue head that is
// prefetched from the two-bank ready queue RAM. The quantum register may be
// written through the csr_ port, which is always ready, while no tick is in
// flight. Queue contents need no clearing after reset.
module round_robin_task_scheduler_core
   import rrts_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_arrive,
   input  logic [7:0]  req_new_id,
   input  logic [11:0] req_new_burst,
   output logic        rsp_valid,
   output logic        rsp_busy_res,
   output logic [7:0]  rsp_running_id,
   output logic        rsp_idle,
   output logic        rsp_finished,
   output logic [7:0]  rsp_finished_id,
   output logic [15:0] rsp_wait_ticks,
   output logic [15:0] rsp_turnaround_ticks,
   output logic [15:0] rsp_response_ticks,
   output logic [1:0]  rsp_switches,
   output logic        rsp_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   logic            accept;
   logic [7:0]      quantum_ff;
   logic [15:0]     tick_ff;
   logic [7:0]      slice_ff, slice_in;
   logic            cur_valid_ff, cur_valid_in;
   task_type        cur_ff, cur_in;

   queue_ctrl_type  qctrl;
   task_type        rec0;
   task_type        head_rec;
   logic [CntW-1:0] count;

   task_type        arr_rec, front, t;
   logic            arr_ok, rq_ok, requeue;
   logic [CntW-1:0] c1, cnt;
   logic [15:0]     turn;

   logic        busy_res_in, idle_in, fin_in, ovf_in;
   logic [7:0]  run_id_in, fin_id_in;
   logic [15:0] wait_in, turn_in, resp_in;
   logic [1:0]  sw_in;

   logic        rsp_valid_ff;
   logic        rsp_busy_res_ff, rsp_idle_ff, rsp_finished_ff, rsp_overflow_ff;
   logic [7:0]  rsp_running_id_ff, rsp_finished_id_ff;
   logic [15:0] rsp_wait_ff, rsp_turn_ff, rsp_resp_ff;
   logic [1:0]  rsp_switches_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_comb begin
      arr_rec.id        = req_new_id;
      arr_rec.burst     = req_new_burst;
      arr_rec.remaining = req_new_burst;
      arr_rec.arrival   = tick_ff;
      arr_rec.first_run = '0;

      arr_ok  = req_arrive && (count < CntW'(QUEUE_DEPTH));
      c1      = count + CntW'(arr_ok);
      requeue = (tick_ff != '0) && (slice_ff >= quantum_ff);
      rq_ok   = c1 < CntW'(QUEUE_DEPTH);

      // With an empty queue the head is whatever was pushed first on this tick.
      front = (count != '0) ? head_rec : (arr_ok ? arr_rec : cur_ff);

      t            = cur_ff;
      cnt          = c1;
      slice_in     = slice_ff;
      cur_valid_in = cur_valid_ff;
      qctrl.pop    = 1'b0;
      rq_ok        = rq_ok && cur_valid_ff && requeue;
      busy_res_in  = 1'b0;
      run_id_in    = '0;
      idle_in      = 1'b0;
      fin_in       = 1'b0;
      fin_id_in    = '0;
      wait_in      = '0;
      turn_in      = '0;
      resp_in      = '0;
      sw_in        = '0;
      ovf_in       = req_arrive && !arr_ok;
      turn         = '0;

      if (!cur_valid_ff) begin
         if (c1 != '0) begin
            qctrl.pop = 1'b1;
            t = front;
            if (t.burst == t.remaining) begin
               t.first_run = tick_ff;
            end
            if (t.remaining != '0) begin
               t.remaining = t.remaining - 12'd1;
            end
            if (slice_in != SLICE_MAX) begin
               slice_in = slice_in + 8'd1;
            end
            cur_valid_in = 1'b1;
            busy_res_in  = 1'b1;
            run_id_in    = t.id;
         end else begin
            idle_in = 1'b1;
         end
      end else begin
         if (requeue) begin
            if (!rq_ok) begin
               ovf_in = 1'b1;
            end
            qctrl.pop = 1'b1;
            cnt       = c1 + CntW'(rq_ok) - CntW'(1);
            t         = front;
            sw_in     = 2'd1;
            slice_in  = '0;
            if (t.burst == t.remaining) begin
               t.first_run = tick_ff;
            end
         end
         busy_res_in = 1'b1;
         run_id_in   = t.id;
         if (t.remaining <= 12'd1) begin
            turn      = tick_ff + 16'd1 - t.arrival;
            fin_in    = 1'b1;
            fin_id_in = t.id;
            turn_in   = turn;
            wait_in   = turn - {4'b0, t.burst};
            resp_in   = t.first_run - t.arrival;
            if (t.remaining != '0) begin
               t.remaining = t.remaining - 12'd1;
            end
            cur_valid_in = 1'b0;
            if (cnt != '0) begin
               sw_in    = sw_in + 2'd1;
               slice_in = '0;
            end
         end else begin
            t.remaining = t.remaining - 12'd1;
            if (slice_in != SLICE_MAX) begin
               slice_in = slice_in + 8'd1;
            end
         end
      end
      cur_in = t;

      // The arrival goes first in queue order, the requeued task second.
      qctrl.push0 = accept && (arr_ok || rq_ok);
      qctrl.push1 = accept && arr_ok && rq_ok;
      qctrl.pop   = accept && qctrl.pop;
      rec0        = arr_ok ? arr_rec : cur_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff   <= QUANTUM_RESET;
         tick_ff      <= '0;
         slice_ff     <= '0;
         cur_valid_ff <= 1'b0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            quantum_ff <= csr_data;
         end
         rsp_valid_ff <= accept;
         if (accept) begin
            tick_ff      <= tick_ff + 16'd1;
            slice_ff     <= slice_in;
            cur_valid_ff <= cur_valid_in;
            cur_ff       <= cur_in;
         end
      end
      if (accept) begin
         rsp_busy_res_ff    <= busy_res_in;
         rsp_running_id_ff  <= run_id_in;
         rsp_idle_ff        <= idle_in;
         rsp_finished_ff    <= fin_in;
         rsp_finished_id_ff <= fin_id_in;
         rsp_wait_ff        <= wait_in;
         rsp_turn_ff        <= turn_in;
         rsp_resp_ff        <= resp_in;
         rsp_switches_ff    <= sw_in;
         rsp_overflow_ff    <= ovf_in;
      end
   end

   rrts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (qctrl),
      .rec0     (rec0),
      .rec1     (cur_ff),
      .head_rec (head_rec),
      .count    (count)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_busy_res         = rsp_busy_res_ff;
   assign rsp_running_id       = rsp_running_id_ff;
   assign rsp_idle             = rsp_idle_ff;
   assign rsp_finished         = rsp_finished_ff;
   assign rsp_finished_id      = rsp_finished_id_ff;
   assign rsp_wait_ticks       = rsp_wait_ff;
   assign rsp_turnaround_ticks = rsp_turn_ff;
   assign rsp_response_ticks   = rsp_resp_ff;
   assign rsp_switches         = rsp_switches_ff;
   assign rsp_overflow         = rsp_overflow_ff;

   a_rsp_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start))
      else $error("result strobe without a tick in the previous cycle");

   a_idle_is_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_idle |-> !rsp_busy_res && !rsp_finished && rsp_switches == 2'd0)
      else $error("idle tick reports activity");

   a_finish_on_core: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_busy_res && rsp_finished_id == rsp_running_id)
      else $error("finished task is not the running task");

endmodule

### verif/tb_round_robin_task_scheduler_core.sv
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler_core;
   import rrts_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int RUN_LIMIT_CYCLES = 800_000;

   typedef struct packed {
      logic        busy_res;
      logic [7:0]  running_id;
      logic        idle;
      logic        finished;
      logic [7:0]  finished_id;
      logic [15:0] wait_ticks;
      logic [15:0] turnaround_ticks;
      logic [15:0] response_ticks;
      logic [1:0]  switches;
      logic        overflow;
   } tick_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_arrive;
   logic [7:0]  req_new_id;
   logic [11:0] req_new_burst;
   logic        rsp_valid;
   logic        rsp_busy_res;
   logic [7:0]  rsp_running_id;
   logic        rsp_idle;
   logic        rsp_finished;
   logic [7:0]  rsp_finished_id;
   logic [15:0] rsp_wait_ticks;
   logic [15:0] rsp_turnaround_ticks;
   logic [15:0] rsp_response_ticks;
   logic [1:0]  rsp_switches;
   logic        rsp_overflow;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;

   // Scheduler state as the testbench expects it to be.
   task_type    ready_q [QUEUE_DEPTH_DEF];
   int          rq_head;
   int          rq_tail;
   int          rq_count;
   task_type    core_task;
   logic        core_busy;
   int          slice_cnt;
   logic [15:0] tick_cnt;
   logic [7:0]  quantum_q;

   tick_result_type tick_results [$];
   int errors;
   int ticks_sent;
   int ticks_checked;
   int finishes_seen;
   int drops_seen;
   int double_switches;

   round_robin_task_scheduler_core dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_arrive           (req_arrive),
      .req_new_id           (req_new_id),
      .req_new_burst        (req_new_burst),
      .rsp_valid            (rsp_valid),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_running_id       (rsp_running_id),
      .rsp_idle             (rsp_idle),
      .rsp_finished         (rsp_finished),
      .rsp_finished_id      (rsp_finished_id),
      .rsp_wait_ticks       (rsp_wait_ticks),
      .rsp_turnaround_ticks (rsp_turnaround_ticks),
      .rsp_response_ticks   (rsp_response_ticks),
      .rsp_switches         (rsp_switches),
      .rsp_overflow         (rsp_overflow),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(64'd1 * CLOCK_PERIOD * RUN_LIMIT_CYCLES);
      $display("** round_robin_task_scheduler_core: FAILED **");
      $finish;
   end

   // Returns 1 when the queue is full and the task is dropped.
   function automatic logic ready_push(input task_type t);
      if (rq_count >= QUEUE_DEPTH_DEF) return 1'b1;
      ready_q[rq_tail] = t;
      rq_tail = (rq_tail + 1) % QUEUE_DEPTH_DEF;
      rq_count++;
      return 1'b0;
   endfunction

   function automatic task_type ready_pop();
      task_type t;
      t = ready_q[rq_head];
      rq_head = (rq_head + 1) % QUEUE_DEPTH_DEF;
      rq_count--;
      return t;
   endfunction

   // Advances the expected scheduler by one tick and returns what the core reports.
   function automatic tick_result_type schedule_tick(input logic arrive, input logic [7:0] id,
                                                     input logic [11:0] burst);
      tick_result_type r;
      task_type     t;
      logic [15:0]  now;
      logic [15:0]  end_tick;
      r = '0;
      now = tick_cnt;
      if (arrive) begin
         t.id = id;
         t.burst = burst;
         t.remaining = burst;
         t.arrival = now;
         t.first_run = '0;
         if (ready_push(t)) r.overflow = 1'b1;
      end
      if (!core_busy) begin
         if (rq_count > 0) begin
            core_task = ready_pop();
            core_busy = 1'b1;
            if (core_task.burst == core_task.remaining) core_task.first_run = now;
            if (core_task.remaining != 0) core_task.remaining--;
            if (slice_cnt < 255) slice_cnt++;
            r.busy_res = 1'b1;
            r.running_id = core_task.id;
         end else begin
            r.idle = 1'b1;
         end
      end else begin
         // The slice limit is ignored on tick zero, including after the counter wraps.
         if (now != 16'd0 && slice_cnt >= quantum_q) begin
            if (ready_push(core_task)) r.overflow = 1'b1;
            core_task = ready_pop();
            r.switches = 2'd1;
            slice_cnt = 0;
            if (core_task.burst == core_task.remaining) core_task.first_run = now;
         end
         r.busy_res = 1'b1;
         r.running_id = core_task.id;
         if (core_task.remaining <= 12'd1) begin
            end_tick = now + 16'd1;
            core_task.remaining = '0;
            r.finished = 1'b1;
            r.finished_id = core_task.id;
            r.turnaround_ticks = end_tick - core_task.arrival;
            r.wait_ticks = end_tick - core_task.arrival - {4'd0, core_task.burst};
            r.response_ticks = core_task.first_run - core_task.arrival;
            core_busy = 1'b0;
            if (rq_count > 0) begin
               r.switches = r.switches + 2'd1;
               slice_cnt = 0;
            end
         end else begin
            core_task.remaining--;
            if (slice_cnt < 255) slice_cnt++;
         end
      end
      tick_cnt = now + 16'd1;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // Checks each result against the oldest prediction, then predicts any new item.
   always @(posedge clock) begin
      tick_result_type got;
      tick_result_type want;
      if (reset) begin
         rq_head = 0;
         rq_tail = 0;
         rq_count = 0;
         core_task = '0;
         core_busy = 1'b0;
         slice_cnt = 0;
         tick_cnt = '0;
         quantum_q = QUANTUM_RESET;
      end else begin
         if (rsp_valid === 1'b1) begin
            got = {rsp_busy_res, rsp_running_id, rsp_idle, rsp_finished, rsp_finished_id,
                   rsp_wait_ticks, rsp_turnaround_ticks, rsp_response_ticks,
                   rsp_switches, rsp_overflow};
            if (tick_results.size() == 0) begin
               errors++;
               $display("%0t: result arrived with no tick outstanding", $time);
            end else begin
               want = tick_results.pop_front();
               ticks_checked++;
               check_field("busy_res", want.busy_res, got.busy_res);
               check_field("running_id", want.running_id, got.running_id);
               check_field("idle", want.idle, got.idle);
               check_field("finished", want.finished, got.finished);
               check_field("finished_id", want.finished_id, got.finished_id);
               check_field("wait_ticks", want.wait_ticks, got.wait_ticks);
               check_field("turnaround_ticks", want.turnaround_ticks, got.turnaround_ticks);
               check_field("response_ticks", want.response_ticks, got.response_ticks);
               check_field("switches", want.switches, got.switches);
               check_field("overflow", want.overflow, got.overflow);
               if (want.finished) finishes_seen++;
               if (want.overflow) drops_seen++;
               if (want.switches == 2'd2) double_switches++;
            end
         end
         if (start && !busy)
            tick_results.push_back(schedule_tick(req_arrive, req_new_id, req_new_burst));
      end
   end

   task automatic send_tick(input logic arrive, input logic [7:0] id, input logic [11:0] burst);
      start <= 1'b1;
      req_arrive <= arrive;
      req_new_id <= id;
      req_new_burst <= burst;
      do @(posedge clock); while (busy !== 1'b0);
      ticks_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_results_done();
      start <= 1'b0;
      @(posedge clock);
      while (tick_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [7:0] value);
      wait_results_done();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      quantum_q = value;
   endtask

   // Sends empty ticks until the core and the ready queue hold no task.
   task automatic run_until_empty();
      wait_results_done();
      while (core_busy || rq_count != 0) begin
         repeat (32) send_tick(1'b0, 8'($urandom), 12'($urandom));
         wait_results_done();
      end
   endtask

   function automatic logic [11:0] pick_burst();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 12'd0;
      if (r < 5) return 12'($urandom_range(0, 4095));
      if (r < 80) return 12'($urandom_range(1, 8));
      return 12'($urandom_range(9, 40));
   endfunction

   task automatic test_idle_core();
      send_tick(1'b0, 8'hFF, 12'hFFF);
      wait_results_done();
   endtask

   task automatic test_round_robin();
      send_tick(1'b1, 8'd1, 12'd5);
      send_tick(1'b1, 8'd2, 12'd3);
      send_tick(1'b1, 8'd3, 12'd1);
      run_until_empty();
   endtask

   // The longest task is left in the queue to compete with the random traffic.
   task automatic test_field_extremes();
      write_quantum(8'd255);
      send_tick(1'b1, 8'd0, 12'd0);
      send_tick(1'b1, 8'd255, 12'd4095);
      wait_results_done();
   endtask

   task automatic test_quantum_extremes();
      write_quantum(8'd1);
      send_tick(1'b1, 8'h5A, 12'd4);
      send_tick(1'b1, 8'hA5, 12'd3);
      run_until_empty();
      write_quantum(8'd0);
      send_tick(1'b1, 8'h11, 12'd3);
      send_tick(1'b1, 8'h22, 12'd2);
      run_until_empty();
   endtask

   // With a quantum of one the queue grows by one task per tick until pushes drop.
   task automatic test_queue_overflow();
      write_quantum(8'd1);
      for (int i = 0; i < QUEUE_DEPTH_DEF + 2; i++)
         send_tick(1'b1, 8'(i + 8'h40), 12'd8);
      run_until_empty();
   endtask

   task automatic test_random_traffic(input int n_items, input logic with_gaps);
      int arrive_pct;
      logic [7:0] q;
      arrive_pct = 40;
      for (int i = 0; i < n_items; i++) begin
         if (i % 60 == 0) begin
            case ((i / 60) % 5)
               0: q = 8'd1;
               1: q = 8'd255;
               2: q = 8'd0;
               3: q = 8'($urandom_range(2, 12));
               default: q = 8'($urandom_range(1, 255));
            endcase
            write_quantum(q);
            arrive_pct = (q == 8'd1) ? 75 : $urandom_range(20, 60);
         end
         if (with_gaps && i == n_items / 2) wait_results_done();
         if (with_gaps && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 17));
         send_tick($urandom_range(0, 99) < arrive_pct, 8'($urandom), pick_burst());
      end
      wait_results_done();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_arrive = 1'b0;
      req_new_id = '0;
      req_new_burst = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      errors = 0;
      ticks_sent = 0;
      ticks_checked = 0;
      finishes_seen = 0;
      drops_seen = 0;
      double_switches = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_core();
      test_round_robin();
      test_quantum_extremes();
      test_queue_overflow();
      test_field_extremes();
      test_random_traffic(300, 1'b1);
      test_random_traffic(60, 1'b0);

      wait_results_done();
      $display("Sent %0d ticks and checked %0d: %0d completions, %0d dropped pushes,",
               ticks_sent, ticks_checked, finishes_seen, drops_seen);
      $display("%0d double switches, with quanta from 0 to 255, a full ready queue and extreme ids and bursts.",
               double_switches);
      if (errors == 0) begin
         $display("** round_robin_task_scheduler_core: PASSED **");
      end else begin
         $display("** round_robin_task_scheduler_core: FAILED **");
      end
      $finish;
   end

endmodule
